@@ rtl/dlr_pkg.sv @@
`default_nettype none

package dlr_pkg;

   // pixel colour width, fixed by the frame buffer format
   localparam int COLOR_BITS = 24;

   // depth of the command queue and the result queue
   localparam int QUEUE_DEPTH = 2;

   // transaction kind on the request side
   typedef enum logic {
      KIND_LOAD = 1'b0,
      KIND_STEP = 1'b1
   } kind_type;

endpackage

`default_nettype wire

@@ rtl/dlr_fifo.sv @@
`default_nettype none

module dlr_fifo #(
   parameter type item_type = logic,
   parameter int  DEPTH     = 2
) (
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     push,
   input  item_type      push_data,
   output logic          full,
   input  wire logic     pop,
   output item_type      pop_data,
   output logic          empty
);

   localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_BITS = $clog2(DEPTH + 1);

   item_type              store_ff [DEPTH];
   logic [PTR_BITS-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_BITS-1:0]   count_ff, count_in;
   logic                  do_push;
   logic                  do_pop;

   assign full     = (count_ff == CNT_BITS'(DEPTH));
   assign empty    = (count_ff == '0);
   assign pop_data = store_ff[rd_ptr_ff];
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;

   // pointer and occupancy update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         store_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

@@ rtl/dlr_front.sv @@
`default_nettype none

module dlr_front #(
   parameter int  COORD_BITS = 12,
   parameter type cmd_type   = logic
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_push,
   output logic                               req_full,
   input  wire logic                          req_kind,
   input  wire logic [COORD_BITS-1:0]         req_x_begin,
   input  wire logic [COORD_BITS-1:0]         req_y_begin,
   input  wire logic [COORD_BITS-1:0]         req_x_end,
   input  wire logic [COORD_BITS-1:0]         req_y_end,
   input  wire logic [dlr_pkg::COLOR_BITS-1:0] req_line_color,
   output logic                               cmd_push,
   output cmd_type                            cmd_data,
   input  wire logic                          cmd_full
);

   logic                             valid_ff, valid_in;
   logic                             kind_ff;
   logic [COORD_BITS-1:0]            xb_ff, yb_ff, xe_ff, ye_ff;
   logic [dlr_pkg::COLOR_BITS-1:0]   color_ff;
   logic                             accept;
   logic signed [COORD_BITS:0]       dx, dy;
   logic [COORD_BITS-1:0]            adx, ady;
   logic                             x_major;

   assign req_full = valid_ff && cmd_full;
   assign accept   = req_push && !req_full;
   assign cmd_push = valid_ff && !cmd_full;

   // hold stage for one incoming transaction
   always_comb begin
      valid_in = valid_ff;
      if (accept) begin
         valid_in = 1'b1;
      end else if (cmd_push) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         kind_ff  <= req_kind;
         xb_ff    <= req_x_begin;
         yb_ff    <= req_y_begin;
         xe_ff    <= req_x_end;
         ye_ff    <= req_y_end;
         color_ff <= req_line_color;
      end
   end

   // deltas, magnitudes and major axis choice
   always_comb begin
      dx      = $signed({1'b0, xe_ff}) - $signed({1'b0, xb_ff});
      dy      = $signed({1'b0, ye_ff}) - $signed({1'b0, yb_ff});
      adx     = dx[COORD_BITS] ? COORD_BITS'(-dx) : dx[COORD_BITS-1:0];
      ady     = dy[COORD_BITS] ? COORD_BITS'(-dy) : dy[COORD_BITS-1:0];
      x_major = (adx >= ady);
   end

   // classified command for the back end
   always_comb begin
      cmd_data.kind          = dlr_pkg::kind_type'(kind_ff);
      cmd_data.single_point  = (xb_ff == xe_ff) && (yb_ff == ye_ff);
      cmd_data.major_is_x    = x_major;
      cmd_data.major_dir_neg = x_major ? dx[COORD_BITS] : dy[COORD_BITS];
      cmd_data.minor_neg     = x_major ? dy[COORD_BITS] : dx[COORD_BITS];
      cmd_data.x_begin       = xb_ff;
      cmd_data.y_begin       = yb_ff;
      cmd_data.major_begin   = x_major ? xb_ff : yb_ff;
      cmd_data.major_stop    = x_major ? xe_ff : ye_ff;
      cmd_data.minor_begin   = x_major ? yb_ff : xb_ff;
      cmd_data.major_len     = x_major ? adx : ady;
      cmd_data.minor_len     = x_major ? ady : adx;
      cmd_data.color         = color_ff;
   end

endmodule

`default_nettype wire

@@ rtl/dlr_back.sv @@
`default_nettype none

module dlr_back #(
   parameter int  COORD_BITS = 12,
   parameter int  FRAC_BITS  = 16,
   parameter type cmd_type   = logic,
   parameter type rsp_type   = logic
) (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic cmd_empty,
   input  cmd_type   cmd_data,
   output logic      cmd_pop,
   input  wire logic rsp_full,
   output logic      rsp_push,
   output rsp_type   rsp_data
);

   localparam int ACC_BITS   = COORD_BITS + FRAC_BITS + 2;
   localparam int SLOPE_BITS = FRAC_BITS + 2;
   localparam int QUOT_BITS  = FRAC_BITS + 1;
   localparam int CNT_BITS   = $clog2(FRAC_BITS + 1);

   typedef enum logic {
      ST_IDLE,
      ST_DIVIDE
   } state_type;

   state_type                        state_ff, state_in;
   logic                             active_ff, active_in;
   logic                             major_is_x_ff, major_is_x_in;
   logic                             dir_neg_ff, dir_neg_in;
   logic                             minor_neg_ff, minor_neg_in;
   logic [COORD_BITS-1:0]            pos_ff, pos_in;
   logic [COORD_BITS-1:0]            stop_ff, stop_in;
   logic signed [ACC_BITS-1:0]       accum_ff, accum_in;
   logic signed [SLOPE_BITS-1:0]     slope_ff, slope_in;
   logic [dlr_pkg::COLOR_BITS-1:0]   color_ff, color_in;
   logic [COORD_BITS:0]              rem_ff, rem_in;
   logic [COORD_BITS-1:0]            divisor_ff, divisor_in;
   logic [QUOT_BITS-1:0]             quot_ff, quot_in;
   logic [CNT_BITS-1:0]              count_ff, count_in;

   logic                             go;
   logic                             quot_bit;
   logic [COORD_BITS:0]              rem_next;
   logic [QUOT_BITS-1:0]             quot_next;
   logic [COORD_BITS-1:0]            pos_step;
   logic signed [ACC_BITS-1:0]       accum_step;
   logic [COORD_BITS-1:0]            minor_step;
   logic                             last_step;

   assign go       = (state_ff == ST_IDLE) && !cmd_empty && !rsp_full;
   assign cmd_pop  = go;
   assign rsp_push = go;

   // one restoring division step, one quotient bit per cycle
   always_comb begin
      quot_bit  = (rem_ff >= {1'b0, divisor_ff});
      rem_next  = quot_bit ? rem_ff - {1'b0, divisor_ff} : rem_ff;
      quot_next = {quot_ff[QUOT_BITS-2:0], quot_bit};
   end

   // one pixel step along the major axis; accumulator carries the half bias
   always_comb begin
      pos_step   = dir_neg_ff ? pos_ff - 1'b1 : pos_ff + 1'b1;
      accum_step = accum_ff + ACC_BITS'(slope_ff);
      if (accum_step[ACC_BITS-1]) begin
         minor_step = '0;
      end else if (accum_step[COORD_BITS+FRAC_BITS]) begin
         minor_step = '1;
      end else begin
         minor_step = accum_step[COORD_BITS+FRAC_BITS-1:FRAC_BITS];
      end
      last_step = (pos_step == stop_ff);
   end

   // command execution and result build
   always_comb begin
      state_in      = state_ff;
      active_in     = active_ff;
      major_is_x_in = major_is_x_ff;
      dir_neg_in    = dir_neg_ff;
      minor_neg_in  = minor_neg_ff;
      pos_in        = pos_ff;
      stop_in       = stop_ff;
      accum_in      = accum_ff;
      slope_in      = slope_ff;
      color_in      = color_ff;
      rem_in        = rem_ff;
      divisor_in    = divisor_ff;
      quot_in       = quot_ff;
      count_in      = count_ff;

      rsp_data.pixel_x     = '0;
      rsp_data.pixel_y     = '0;
      rsp_data.pixel_color = '0;
      rsp_data.last_pixel  = 1'b0;
      rsp_data.no_line     = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (go) begin
               if (cmd_data.kind == dlr_pkg::KIND_LOAD) begin
                  rsp_data.pixel_x     = cmd_data.x_begin;
                  rsp_data.pixel_y     = cmd_data.y_begin;
                  rsp_data.pixel_color = cmd_data.color;
                  rsp_data.last_pixel  = cmd_data.single_point;
                  color_in             = cmd_data.color;
                  if (cmd_data.single_point) begin
                     active_in = 1'b0;
                  end else begin
                     active_in     = 1'b1;
                     major_is_x_in = cmd_data.major_is_x;
                     dir_neg_in    = cmd_data.major_dir_neg;
                     minor_neg_in  = cmd_data.minor_neg;
                     pos_in        = cmd_data.major_begin;
                     stop_in       = cmd_data.major_stop;
                     accum_in      = {2'b00, cmd_data.minor_begin, 1'b1,
                                      (FRAC_BITS - 1)'(0)};
                     rem_in        = {1'b0, cmd_data.minor_len};
                     divisor_in    = cmd_data.major_len;
                     quot_in       = '0;
                     count_in      = '0;
                     state_in      = ST_DIVIDE;
                  end
               end else if (!active_ff) begin
                  rsp_data.no_line = 1'b1;
               end else begin
                  rsp_data.pixel_x     = major_is_x_ff ? pos_step : minor_step;
                  rsp_data.pixel_y     = major_is_x_ff ? minor_step : pos_step;
                  rsp_data.pixel_color = color_ff;
                  rsp_data.last_pixel  = last_step;
                  pos_in               = pos_step;
                  accum_in             = accum_step;
                  active_in            = !last_step;
               end
            end
         end
         ST_DIVIDE: begin
            rem_in   = {rem_next[COORD_BITS-1:0], 1'b0};
            quot_in  = quot_next;
            count_in = count_ff + 1'b1;
            if (count_ff == CNT_BITS'(FRAC_BITS)) begin
               slope_in = minor_neg_ff ? -$signed({1'b0, quot_next})
                                       : $signed({1'b0, quot_next});
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         active_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         active_ff <= active_in;
      end
      major_is_x_ff <= major_is_x_in;
      dir_neg_ff    <= dir_neg_in;
      minor_neg_ff  <= minor_neg_in;
      pos_ff        <= pos_in;
      stop_ff       <= stop_in;
      accum_ff      <= accum_in;
      slope_ff      <= slope_in;
      color_ff      <= color_in;
      rem_ff        <= rem_in;
      divisor_ff    <= divisor_in;
      quot_ff       <= quot_in;
      count_ff      <= count_in;
   end

endmodule

`default_nettype wire

@@ rtl/dda_line_rasterizer.sv @@
`default_nettype none

// DDA line rasterizer. Push a load transaction (kind 0) with two endpoints
// and a colour and the start pixel comes back; push step transactions
// (kind 1) to get the following pixels one by one, the pixel at the end
// point flagged last_pixel. A step with no line in progress returns a
// result with no_line set and all other fields zero. Every request gives
// exactly one result, in order. Requests pass through a one-entry input
// stage and a two-entry command queue; results leave through a two-entry
// result queue, so the request side keeps taking transactions while a
// result waits to be popped. A step is handled in the back end's idle state;
// with all queues empty its result passes the input stage register, the
// command queue and the result queue before it is on the result ports. A
// load that is not a single point also occupies the back end while a
// bit-serial restoring divider forms the minor-axis slope, so a step queued
// behind it waits for that divider.

module dda_line_rasterizer #(
   parameter int COORD_BITS = 12,
   parameter int FRAC_BITS  = 16
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_push,
   output logic                                req_full,
   input  wire logic                           req_kind,
   input  wire logic [COORD_BITS-1:0]          req_x_begin,
   input  wire logic [COORD_BITS-1:0]          req_y_begin,
   input  wire logic [COORD_BITS-1:0]          req_x_end,
   input  wire logic [COORD_BITS-1:0]          req_y_end,
   input  wire logic [dlr_pkg::COLOR_BITS-1:0] req_line_color,
   output logic                                rsp_empty,
   input  wire logic                           rsp_pop,
   output logic [COORD_BITS-1:0]               rsp_pixel_x,
   output logic [COORD_BITS-1:0]               rsp_pixel_y,
   output logic [dlr_pkg::COLOR_BITS-1:0]      rsp_pixel_color,
   output logic                                rsp_last_pixel,
   output logic                                rsp_no_line
);

   // classified command between front and back end
   typedef struct packed {
      dlr_pkg::kind_type                kind;
      logic                             single_point;
      logic                             major_is_x;
      logic                             major_dir_neg;
      logic                             minor_neg;
      logic [COORD_BITS-1:0]            x_begin;
      logic [COORD_BITS-1:0]            y_begin;
      logic [COORD_BITS-1:0]            major_begin;
      logic [COORD_BITS-1:0]            major_stop;
      logic [COORD_BITS-1:0]            minor_begin;
      logic [COORD_BITS-1:0]            major_len;
      logic [COORD_BITS-1:0]            minor_len;
      logic [dlr_pkg::COLOR_BITS-1:0]   color;
   } cmd_type;

   // one result transaction
   typedef struct packed {
      logic [COORD_BITS-1:0]            pixel_x;
      logic [COORD_BITS-1:0]            pixel_y;
      logic [dlr_pkg::COLOR_BITS-1:0]   pixel_color;
      logic                             last_pixel;
      logic                             no_line;
   } rsp_type;

   logic    cmd_push, cmd_full, cmd_pop, cmd_empty;
   cmd_type cmd_in_data, cmd_out_data;
   logic    res_push, res_full;
   rsp_type res_in_data, res_out_data;

   dlr_front #(
      .COORD_BITS (COORD_BITS),
      .cmd_type   (cmd_type)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .req_push       (req_push),
      .req_full       (req_full),
      .req_kind       (req_kind),
      .req_x_begin    (req_x_begin),
      .req_y_begin    (req_y_begin),
      .req_x_end      (req_x_end),
      .req_y_end      (req_y_end),
      .req_line_color (req_line_color),
      .cmd_push       (cmd_push),
      .cmd_data       (cmd_in_data),
      .cmd_full       (cmd_full)
   );

   dlr_fifo #(
      .item_type (cmd_type),
      .DEPTH     (dlr_pkg::QUEUE_DEPTH)
   ) u_cmd_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (cmd_push),
      .push_data (cmd_in_data),
      .full      (cmd_full),
      .pop       (cmd_pop),
      .pop_data  (cmd_out_data),
      .empty     (cmd_empty)
   );

   dlr_back #(
      .COORD_BITS (COORD_BITS),
      .FRAC_BITS  (FRAC_BITS),
      .cmd_type   (cmd_type),
      .rsp_type   (rsp_type)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_empty (cmd_empty),
      .cmd_data  (cmd_out_data),
      .cmd_pop   (cmd_pop),
      .rsp_full  (res_full),
      .rsp_push  (res_push),
      .rsp_data  (res_in_data)
   );

   dlr_fifo #(
      .item_type (rsp_type),
      .DEPTH     (dlr_pkg::QUEUE_DEPTH)
   ) u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (res_push),
      .push_data (res_in_data),
      .full      (res_full),
      .pop       (rsp_pop),
      .pop_data  (res_out_data),
      .empty     (rsp_empty)
   );

   assign rsp_pixel_x     = res_out_data.pixel_x;
   assign rsp_pixel_y     = res_out_data.pixel_y;
   assign rsp_pixel_color = res_out_data.pixel_color;
   assign rsp_last_pixel  = res_out_data.last_pixel;
   assign rsp_no_line     = res_out_data.no_line;

   // each command taken by the back end yields exactly one result
   a_one_result_per_cmd: assert property (@(posedge clock) disable iff (reset)
      cmd_pop == res_push)
      else $error("command and result counts diverge");

   // back end never writes into a full result queue
   a_no_result_overflow: assert property (@(posedge clock) disable iff (reset)
      res_full |-> !res_push)
      else $error("result pushed into full queue");

   // back end never takes from an empty command queue
   a_no_cmd_underflow: assert property (@(posedge clock) disable iff (reset)
      cmd_empty |-> !cmd_pop)
      else $error("command popped from empty queue");

   // a no-line result carries nothing else
   a_no_line_clean: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_no_line) |-> (rsp_pixel_x == '0 && rsp_pixel_y == '0 &&
         rsp_pixel_color == '0 && !rsp_last_pixel))
      else $error("no-line result with non-zero fields");

endmodule

`default_nettype wire

@@ dv/line_pixel_checker.sv @@
`default_nettype none

module line_pixel_checker #(
   parameter int COORD_BITS = 12,
   parameter int FRAC_BITS  = 16
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_push,
   input  wire logic                           req_full,
   input  wire logic                           req_kind,
   input  wire logic [COORD_BITS-1:0]          req_x_begin,
   input  wire logic [COORD_BITS-1:0]          req_y_begin,
   input  wire logic [COORD_BITS-1:0]          req_x_end,
   input  wire logic [COORD_BITS-1:0]          req_y_end,
   input  wire logic [dlr_pkg::COLOR_BITS-1:0] req_line_color,
   input  wire logic                           rsp_empty,
   input  wire logic                           rsp_pop,
   input  wire logic [COORD_BITS-1:0]          rsp_pixel_x,
   input  wire logic [COORD_BITS-1:0]          rsp_pixel_y,
   input  wire logic [dlr_pkg::COLOR_BITS-1:0] rsp_pixel_color,
   input  wire logic                           rsp_last_pixel,
   input  wire logic                           rsp_no_line,
   output int                                  fail_count,
   output int                                  pending_count,
   output int                                  line_ends,
   output int                                  empty_steps
);

   localparam int ACC_BITS = COORD_BITS + FRAC_BITS + 2;
   localparam logic signed [ACC_BITS:0] HALF_UNIT = (ACC_BITS + 1)'(1) <<< (FRAC_BITS - 1);

   typedef struct packed {
      logic [COORD_BITS-1:0]          x;
      logic [COORD_BITS-1:0]          y;
      logic [dlr_pkg::COLOR_BITS-1:0] colour;
      logic                           last;
      logic                           no_line;
   } pixel_type;

   // predicted pixels, oldest first
   pixel_type pixels_due[$];
   int        mismatches = 0;
   int        ends_seen = 0;
   int        empties_seen = 0;

   // rasterizer state as the predictor sees it
   logic                           line_on;
   logic                           x_major;
   logic                           heading_down;
   logic [COORD_BITS-1:0]          major_at;
   logic [COORD_BITS-1:0]          major_last;
   logic signed [ACC_BITS-1:0]     minor_acc;
   logic signed [FRAC_BITS+1:0]    slope;
   logic [dlr_pkg::COLOR_BITS-1:0] colour_held;

   // next pixel of the line for one request transaction, state updated in place
   function automatic pixel_type trace_line_pixel(
      input logic                           kind,
      input logic [COORD_BITS-1:0]          xb,
      input logic [COORD_BITS-1:0]          yb,
      input logic [COORD_BITS-1:0]          xe,
      input logic [COORD_BITS-1:0]          ye,
      input logic [dlr_pkg::COLOR_BITS-1:0] colour
   );
      logic signed [COORD_BITS:0]      dx;
      logic signed [COORD_BITS:0]      dy;
      logic signed [COORD_BITS:0]      dminor;
      logic [COORD_BITS-1:0]           adx;
      logic [COORD_BITS-1:0]           ady;
      logic [COORD_BITS-1:0]           amajor;
      logic [COORD_BITS-1:0]           aminor;
      logic [COORD_BITS-1:0]           minor_from;
      logic [COORD_BITS-1:0]           minor;
      logic [COORD_BITS+FRAC_BITS-1:0] quot;
      logic signed [FRAC_BITS+1:0]     magnitude;
      logic signed [ACC_BITS:0]        rounded;
      pixel_type                       px;
      px = '0;
      if (kind == dlr_pkg::KIND_LOAD) begin
         dx = $signed({1'b0, xe}) - $signed({1'b0, xb});
         dy = $signed({1'b0, ye}) - $signed({1'b0, yb});
         adx = COORD_BITS'(dx < 0 ? -dx : dx);
         ady = COORD_BITS'(dy < 0 ? -dy : dy);
         colour_held = colour;
         px.x = xb;
         px.y = yb;
         px.colour = colour;
         if (dx == 0 && dy == 0) begin
            // single point line: done at once
            line_on = 1'b0;
            px.last = 1'b1;
         end else begin
            x_major = (adx >= ady);
            if (x_major) begin
               amajor = adx;
               aminor = ady;
               dminor = dy;
               heading_down = (dx < 0);
               major_at = xb;
               major_last = xe;
               minor_from = yb;
            end else begin
               amajor = ady;
               aminor = adx;
               dminor = dx;
               heading_down = (dy < 0);
               major_at = yb;
               major_last = ye;
               minor_from = xb;
            end
            // truncated fixed point slope, sign applied afterwards
            quot = {aminor, FRAC_BITS'(0)} / amajor;
            magnitude = $signed({1'b0, quot[FRAC_BITS:0]});
            slope = (dminor < 0) ? -magnitude : magnitude;
            minor_acc = $signed({2'b00, minor_from, FRAC_BITS'(0)});
            line_on = 1'b1;
         end
      end else if (!line_on) begin
         px.no_line = 1'b1;
      end else begin
         major_at = heading_down ? major_at - 1'b1 : major_at + 1'b1;
         minor_acc = minor_acc + slope;
         // round half up, clamp to the coordinate range
         rounded = minor_acc + HALF_UNIT;
         if (rounded < 0)
            minor = '0;
         else if ((rounded >>> FRAC_BITS) > (1 << COORD_BITS) - 1)
            minor = '1;
         else
            minor = rounded[FRAC_BITS +: COORD_BITS];
         px.last = (major_at == major_last);
         if (px.last)
            line_on = 1'b0;
         px.colour = colour_held;
         if (x_major) begin
            px.x = major_at;
            px.y = minor;
         end else begin
            px.x = minor;
            px.y = major_at;
         end
      end
      return px;
   endfunction

   // watch both channels, predict on request, compare on result
   always @(posedge clock) begin
      pixel_type seen;
      pixel_type want;
      if (reset) begin
         pixels_due.delete();
         line_on = 1'b0;
         x_major = 1'b0;
         heading_down = 1'b0;
         major_at = '0;
         major_last = '0;
         minor_acc = '0;
         slope = '0;
         colour_held = '0;
      end else begin
         if (rsp_pop && !rsp_empty) begin
            seen = {rsp_pixel_x, rsp_pixel_y, rsp_pixel_color, rsp_last_pixel,
                    rsp_no_line};
            if (pixels_due.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected pixel transaction: %s%0d y=%0d colour=%06h %s%0b",
                           "x=", seen.x, seen.y, seen.colour, "last=", seen.last);
            end else begin
               want = pixels_due.pop_front();
               if (want.last)
                  ends_seen++;
               if (want.no_line)
                  empties_seen++;
               if (seen !== want) begin
                  mismatches++;
                  if (mismatches <= 10) begin
                     $display("pixel mismatch: expected x=%0d y=%0d colour=%06h %s%0b %s%0b",
                              want.x, want.y, want.colour, "last=", want.last,
                              "no_line=", want.no_line);
                     $display("                got      x=%0d y=%0d colour=%06h %s%0b %s%0b",
                              seen.x, seen.y, seen.colour, "last=", seen.last,
                              "no_line=", seen.no_line);
                  end
               end
            end
         end
         if (req_push && !req_full)
            pixels_due.push_back(trace_line_pixel(req_kind, req_x_begin, req_y_begin,
                                                  req_x_end, req_y_end, req_line_color));
      end
      fail_count    <= mismatches;
      pending_count <= pixels_due.size();
      line_ends     <= ends_seen;
      empty_steps   <= empties_seen;
   end

endmodule

`default_nettype wire

@@ dv/tb_top.sv @@
`default_nettype none

module tb_top;

   localparam int COORD_BITS  = 12;
   localparam int ITEM_TARGET = 1650;
   localparam int CYCLE_LIMIT = 400000;

   logic                           clock = 1'b0;
   logic                           reset;
   logic                           req_push;
   logic                           req_full;
   logic                           req_kind;
   logic [COORD_BITS-1:0]          req_x_begin;
   logic [COORD_BITS-1:0]          req_y_begin;
   logic [COORD_BITS-1:0]          req_x_end;
   logic [COORD_BITS-1:0]          req_y_end;
   logic [dlr_pkg::COLOR_BITS-1:0] req_line_color;
   logic                           rsp_empty;
   logic                           rsp_pop;
   logic [COORD_BITS-1:0]          rsp_pixel_x;
   logic [COORD_BITS-1:0]          rsp_pixel_y;
   logic [dlr_pkg::COLOR_BITS-1:0] rsp_pixel_color;
   logic                           rsp_last_pixel;
   logic                           rsp_no_line;

   int fail_count;
   int pending_count;
   int line_ends;
   int empty_steps;

   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int items_sent = 0;
   int loads_sent = 0;
   int cycle_count = 0;

   dda_line_rasterizer #(
      .COORD_BITS(COORD_BITS),
      .FRAC_BITS (16)
   ) dut (
      .clock          (clock),
      .reset          (reset),
      .req_push       (req_push),
      .req_full       (req_full),
      .req_kind       (req_kind),
      .req_x_begin    (req_x_begin),
      .req_y_begin    (req_y_begin),
      .req_x_end      (req_x_end),
      .req_y_end      (req_y_end),
      .req_line_color (req_line_color),
      .rsp_empty      (rsp_empty),
      .rsp_pop        (rsp_pop),
      .rsp_pixel_x    (rsp_pixel_x),
      .rsp_pixel_y    (rsp_pixel_y),
      .rsp_pixel_color(rsp_pixel_color),
      .rsp_last_pixel (rsp_last_pixel),
      .rsp_no_line    (rsp_no_line)
   );

   line_pixel_checker #(
      .COORD_BITS(COORD_BITS),
      .FRAC_BITS (16)
   ) checker_i (
      .clock          (clock),
      .reset          (reset),
      .req_push       (req_push),
      .req_full       (req_full),
      .req_kind       (req_kind),
      .req_x_begin    (req_x_begin),
      .req_y_begin    (req_y_begin),
      .req_x_end      (req_x_end),
      .req_y_end      (req_y_end),
      .req_line_color (req_line_color),
      .rsp_empty      (rsp_empty),
      .rsp_pop        (rsp_pop),
      .rsp_pixel_x    (rsp_pixel_x),
      .rsp_pixel_y    (rsp_pixel_y),
      .rsp_pixel_color(rsp_pixel_color),
      .rsp_last_pixel (rsp_last_pixel),
      .rsp_no_line    (rsp_no_line),
      .fail_count     (fail_count),
      .pending_count  (pending_count),
      .line_ends      (line_ends),
      .empty_steps    (empty_steps)
   );

   always #4 clock = ~clock;

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("Regression FAIL");
         $finish;
      end
   end

   // result side: pop at random, per the current idle profile
   always @(posedge clock) begin
      rsp_pop <= ($urandom_range(99) >= recv_idle_pct);
   end

   // one request transaction, with random idle cycles ahead of it
   task automatic push_item(input dlr_pkg::kind_type kind,
                            input logic [COORD_BITS-1:0] xb, input logic [COORD_BITS-1:0] yb,
                            input logic [COORD_BITS-1:0] xe, input logic [COORD_BITS-1:0] ye,
                            input logic [dlr_pkg::COLOR_BITS-1:0] colour);
      while ($urandom_range(99) < send_idle_pct) begin
         req_push <= 1'b0;
         @(posedge clock);
      end
      req_push       <= 1'b1;
      req_kind       <= kind;
      req_x_begin    <= xb;
      req_y_begin    <= yb;
      req_x_end      <= xe;
      req_y_end      <= ye;
      req_line_color <= colour;
      do @(posedge clock); while (req_full);
      items_sent++;
      if (kind == dlr_pkg::KIND_LOAD)
         loads_sent++;
   endtask

   // step transactions carry junk in the ignored fields
   task automatic step_line(input int count);
      repeat (count)
         push_item(dlr_pkg::KIND_STEP, COORD_BITS'($urandom), COORD_BITS'($urandom),
                   COORD_BITS'($urandom), COORD_BITS'($urandom),
                   dlr_pkg::COLOR_BITS'($urandom));
   endtask

   function automatic logic [COORD_BITS-1:0] random_coord();
      if ($urandom_range(19) == 0)
         return $urandom_range(1) ? '1 : '0;
      return COORD_BITS'($urandom);
   endfunction

   function automatic logic [COORD_BITS-1:0] near_coord(input logic [COORD_BITS-1:0] base,
                                                        input int span);
      int d;
      d = $urandom_range(span);
      if ((int'(base) + d <= (1 << COORD_BITS) - 1) && ($urandom_range(1) || int'(base) < d))
         return base + COORD_BITS'(d);
      return base - COORD_BITS'(d);
   endfunction

   // one random line: mostly short and run to its end, some cut short or overrun
   task automatic draw_random_line();
      logic [COORD_BITS-1:0] xb;
      logic [COORD_BITS-1:0] yb;
      logic [COORD_BITS-1:0] xe;
      logic [COORD_BITS-1:0] ye;
      int shape;
      int span;
      int steps;
      int pick;
      shape = $urandom_range(99);
      xb = random_coord();
      yb = random_coord();
      if (shape < 5) begin
         xe = xb;
         ye = yb;
      end else if (shape < 15) begin
         xe = random_coord();
         ye = random_coord();
      end else if (shape < 22) begin
         // stray step or noise load
         if ($urandom_range(1))
            step_line(1);
         else
            push_item(dlr_pkg::KIND_LOAD, xb, yb, near_coord(xb, 3), near_coord(yb, 3),
                      dlr_pkg::COLOR_BITS'($urandom));
         return;
      end else begin
         xe = near_coord(xb, 24);
         ye = near_coord(yb, 24);
      end
      span = int'((xe > xb) ? xe - xb : xb - xe);
      if (int'((ye > yb) ? ye - yb : yb - ye) > span)
         span = int'((ye > yb) ? ye - yb : yb - ye);
      push_item(dlr_pkg::KIND_LOAD, xb, yb, xe, ye, dlr_pkg::COLOR_BITS'($urandom));
      pick = $urandom_range(99);
      if (span > 48)
         steps = $urandom_range(48);
      else if (pick < 70)
         steps = span;
      else if (pick < 85)
         steps = span + $urandom_range(1, 3);
      else
         steps = $urandom_range(span);
      step_line(steps);
   endtask

   initial begin
      reset          <= 1'b1;
      req_push       <= 1'b0;
      req_kind       <= dlr_pkg::KIND_LOAD;
      req_x_begin    <= '0;
      req_y_begin    <= '0;
      req_x_end      <= '0;
      req_y_end      <= '0;
      req_line_color <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // first profile: sender idles lightly, receiver heavily
      send_idle_pct = 23;
      recv_idle_pct = 62;

      // directed: step with nothing loaded, single point line
      step_line(1);
      push_item(dlr_pkg::KIND_LOAD, 12'd5, 12'd5, 12'd5, 12'd5, 24'hffffff);
      step_line(1);
      // shallow line in +x, run to the end and one past it
      push_item(dlr_pkg::KIND_LOAD, 12'd0, 12'd0, 12'd3, 12'd1, 24'h000000);
      step_line(4);
      // steep line heading down both axes from the far corner, cut short
      push_item(dlr_pkg::KIND_LOAD, 12'hfff, 12'hfff, 12'hffd, 12'd0, 24'ha5a5a5);
      step_line(2);
      // load over a line still in progress
      push_item(dlr_pkg::KIND_LOAD, 12'hfff, 12'd0, 12'd0, 12'hfff, 24'h5a5a5a);
      step_line(2);
      // horizontal along the top edge
      push_item(dlr_pkg::KIND_LOAD, 12'd0, 12'hfff, 12'hfff, 12'hfff, 24'h123456);
      step_line(1);
      // exact diagonal: tie goes to the x axis
      push_item(dlr_pkg::KIND_LOAD, 12'd10, 12'd20, 12'd13, 12'd23, 24'h800001);
      step_line(3);
      // vertical
      push_item(dlr_pkg::KIND_LOAD, 12'd100, 12'd0, 12'd100, 12'd2, 24'h7fffff);
      step_line(2);
      // minor lands exactly on a half and rounds up
      push_item(dlr_pkg::KIND_LOAD, 12'd0, 12'd0, 12'd2, 12'd1, 24'h00ff00);
      step_line(1);

      // random lines over the three idle profiles
      while (items_sent < ITEM_TARGET) begin
         if (items_sent >= 2 * ITEM_TARGET / 3) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end else if (items_sent >= ITEM_TARGET / 3) begin
            send_idle_pct = 62;
            recv_idle_pct = 23;
         end
         draw_random_line();
      end
      req_push <= 1'b0;

      // drain, then a short tail for stray results
      do @(posedge clock); while (pending_count != 0);
      repeat (20) @(posedge clock);

      $display("sent %0d transactions (%0d loads) under three idle profiles",
               items_sent, loads_sent);
      $display("saw %0d line ends and %0d steps with no line", line_ends, empty_steps);
      if (fail_count == 0 && pending_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("%0d failures, %0d results missing", fail_count, pending_count);
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

`default_nettype wire
